### sv/esc_pkg.sv
package esc_pkg;

    // request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_LANDING = 2'd1,
        REQ_INSIDE  = 2'd2,
        REQ_CLOSE   = 2'd3
    } req_t;

    // travel direction, two-bit signed code
    typedef enum logic [1:0] {
        DIR_STOP = 2'b00,
        DIR_UP   = 2'b01,
        DIR_DOWN = 2'b11
    } dir_t;

    // door event reported with each result
    typedef enum logic [1:0] {
        DOOR_NONE   = 2'd0,
        DOOR_OPENED = 2'd1,
        DOOR_CLOSED = 2'd2
    } door_evt_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_NUM_LEVELS  = 2'd0,
        CFG_MOVE_DELAY  = 2'd1,
        CFG_START_DELAY = 2'd2,
        CFG_STOP_DELAY  = 2'd3
    } cfg_idx_t;

    localparam logic [7:0] DEFAULT_DELAY   = 8'd5;
    localparam logic [4:0] RST_NUM_LEVELS  = 5'd3;
    localparam logic [7:0] RST_MOVE_DELAY  = 8'd10;
    localparam logic [7:0] RST_START_DELAY = 8'd15;
    localparam logic [7:0] RST_STOP_DELAY  = 8'd20;

    // result fields in tdata order
    typedef struct packed {
        logic [7:0] time_left;
        logic       rejected;
        door_evt_t  door_event;
        logic       arrived;
        logic       doors_open;
        dir_t       direction;
        logic [3:0] floor;
    } result_t;

    // zero delay register means the default delay
    function automatic logic [7:0] load_delay(input logic [7:0] d);
        return (d != 8'd0) ? d : DEFAULT_DELAY;
    endfunction

endpackage

### sv/elevator_shuttle_controller.sv
// a result beat is registered and appears in the cycle after its input beat is accepted
// throughput: one input beat per cycle; the single result register is the only
//   buffer, so s_tready follows m_tready while a result is waiting
// reset (aresetn low, synchronous): car at floor index 1 going up, doors closed,
//   no calls latched, countdown 1, registers back to 3, 10, 15, 20
module elevator_shuttle_controller
    import esc_pkg::*;
#(
    parameter int MAX_FLOORS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [4:0] level, [7:5] zero
    input  logic [1:0]  s_tuser,    // [1:0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // [3:0] floor, [5:4] direction, [6] doors_open,
                                    // [7] arrived, [9:8] door_event, [10] rejected,
                                    // [18:11] time_left, [23:19] zero
);

    localparam int FW = (MAX_FLOORS > 2) ? $clog2(MAX_FLOORS) : 1;
    localparam int NW = ($clog2(MAX_FLOORS + 1) > 5) ? $clog2(MAX_FLOORS + 1) : 5;
    localparam logic [FW-1:0] TOP_FLOOR  = FW'(MAX_FLOORS - 1);
    localparam logic [FW-1:0] FLOOR_MASK = FW'(MAX_FLOORS - 1);
    localparam logic [NW-1:0] MAX_N      = NW'(MAX_FLOORS);

    // configuration registers
    logic [4:0] num_levels_reg;
    logic [7:0] move_delay_reg, start_delay_reg, stop_delay_reg;

    // car state
    logic [FW-1:0]         car_floor_reg, car_floor_next;
    dir_t                  car_dir_reg, car_dir_next;
    dir_t                  saved_dir_reg, saved_dir_next;
    logic                  doors_reg, doors_next;
    logic [MAX_FLOORS-1:0] calls_reg, calls_next;
    logic [7:0]            countdown_reg, countdown_next;

    // result register
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t res;

    logic          accept;
    req_t          req;
    logic [4:0]    lvl;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] lvl_ext;
    logic [FW-1:0] moved_floor;
    logic [FW-1:0] call_idx;
    logic [FW-1:0] step_idx;
    logic          arrived;
    door_evt_t     door_event;
    logic          rejected;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign req      = req_t'(s_tuser);
    assign lvl      = s_tdata[4:0];
    assign lvl_ext  = NW'(lvl);

    // floor count clamped to 2..MAX_FLOORS
    always_comb begin
        if (NW'(num_levels_reg) < NW'(2)) begin
            n_eff = NW'(2);
        end else if (NW'(num_levels_reg) > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = NW'(num_levels_reg);
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_levels_reg  <= RST_NUM_LEVELS;
            move_delay_reg  <= RST_MOVE_DELAY;
            start_delay_reg <= RST_START_DELAY;
            stop_delay_reg  <= RST_STOP_DELAY;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_NUM_LEVELS:  num_levels_reg  <= cfg_wdata[4:0];
                CFG_MOVE_DELAY:  move_delay_reg  <= cfg_wdata;
                CFG_START_DELAY: start_delay_reg <= cfg_wdata;
                CFG_STOP_DELAY:  stop_delay_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // one floor of travel, saturated at both ends of the shaft
    always_comb begin
        moved_floor = car_floor_reg;
        if (car_dir_reg == DIR_UP) begin
            if (car_floor_reg < TOP_FLOOR) begin
                moved_floor = car_floor_reg + FW'(1);
            end
        end else if (car_floor_reg != FW'(0)) begin
            moved_floor = car_floor_reg - FW'(1);
        end
    end

    assign step_idx = moved_floor & FLOOR_MASK;
    assign call_idx = FW'(lvl - 5'd1) & FLOOR_MASK;

    // item processing
    always_comb begin
        car_floor_next = car_floor_reg;
        car_dir_next   = car_dir_reg;
        saved_dir_next = saved_dir_reg;
        doors_next     = doors_reg;
        calls_next     = calls_reg;
        countdown_next = countdown_reg;
        arrived        = 1'b0;
        door_event     = DOOR_NONE;
        rejected       = 1'b0;
        case (req) inside
            REQ_TICK: begin
                if (countdown_reg > 8'd1) begin
                    countdown_next = countdown_reg - 8'd1;
                end else if (car_dir_reg != DIR_STOP) begin
                    // move one floor, reverse at the ends, stop on a call
                    car_floor_next = moved_floor;
                    arrived        = 1'b1;
                    if (moved_floor == FW'(0)) begin
                        car_dir_next = DIR_UP;
                    end
                    if (NW'(moved_floor) >= n_eff - NW'(1)) begin
                        car_dir_next = DIR_DOWN;
                    end
                    if (calls_reg[step_idx]) begin
                        calls_next[step_idx] = 1'b0;
                        doors_next           = 1'b1;
                        door_event           = DOOR_OPENED;
                        saved_dir_next       = car_dir_next;
                        car_dir_next         = DIR_STOP;
                        countdown_next       = load_delay(stop_delay_reg);
                    end else begin
                        countdown_next = load_delay(move_delay_reg);
                    end
                end else begin
                    // close doors and resume travel
                    doors_next     = 1'b0;
                    door_event     = DOOR_CLOSED;
                    car_dir_next   = saved_dir_reg;
                    countdown_next = load_delay(start_delay_reg);
                end
            end
            REQ_LANDING, REQ_INSIDE: begin
                if (lvl == 5'd0 || lvl_ext > n_eff) begin
                    rejected = 1'b1;
                end else begin
                    calls_next[call_idx] = 1'b1;
                    if (req == REQ_INSIDE && doors_reg) begin
                        countdown_next = 8'd1;
                    end
                end
            end
            default: begin
                if (doors_reg) begin
                    countdown_next = 8'd1;
                end else begin
                    rejected = 1'b1;
                end
            end
        endcase
    end

    // result fields
    always_comb begin
        res.floor      = 4'(32'(car_floor_next));
        res.direction  = car_dir_next;
        res.doors_open = doors_next;
        res.arrived    = arrived;
        res.door_event = door_event;
        res.rejected   = rejected;
        res.time_left  = countdown_next;
    end

    // state update on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            car_floor_reg <= FW'(1);
            car_dir_reg   <= DIR_UP;
            saved_dir_reg <= DIR_UP;
            doors_reg     <= 1'b0;
            calls_reg     <= '0;
            countdown_reg <= 8'd1;
        end else if (accept) begin
            car_floor_reg <= car_floor_next;
            car_dir_reg   <= car_dir_next;
            saved_dir_reg <= saved_dir_next;
            doors_reg     <= doors_next;
            calls_reg     <= calls_next;
            countdown_reg <= countdown_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 24'(out_data_reg);

    // doors are open exactly while the car is stopped
    assert property (@(posedge aclk) disable iff (!aresetn)
        doors_reg == (car_dir_reg == DIR_STOP))
        else $error("doors state and stopped direction disagree");

    // the countdown never rests at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        countdown_reg != 8'd0)
        else $error("countdown reached zero");

    // a stop always leaves a nonzero direction saved for the restart
    assert property (@(posedge aclk) disable iff (!aresetn)
        saved_dir_reg != DIR_STOP)
        else $error("saved direction is stopped");

    // the car stays inside the shaft
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(car_floor_reg) < MAX_FLOORS)
        else $error("car floor out of range");

endmodule

### tb/sv/elevator_shuttle_controller_tb.sv
module elevator_shuttle_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import esc_pkg::*;

    // car limits and the delay used when a delay register holds zero
    localparam logic [4:0] TOP_LEVELS     = 5'd16;
    localparam logic [3:0] LAST_FLOOR     = 4'd15;
    localparam logic [7:0] ZERO_DELAY_SUB = 8'd5;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    elevator_shuttle_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predicted car state and register copies
    logic [4:0]  num_levels_r;
    logic [7:0]  move_delay_r;
    logic [7:0]  start_delay_r;
    logic [7:0]  stop_delay_r;
    logic [3:0]  car_floor;
    dir_t        car_dir;
    dir_t        saved_dir;
    logic        doors_open;
    logic [15:0] calls;
    logic [7:0]  countdown;

    result_t car_status_q[$];
    int      mismatches;
    bit      no_idle;

    // 20 ns clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (!no_idle && $urandom_range(99) < 7) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // compare each result beat with the oldest predicted status
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[18:0]);
            if (car_status_q.size() == 0) begin
                $error("result beat with no prediction pending: 0x%0h", m_tdata);
                mismatches++;
            end else begin
                want = car_status_q.pop_front();
                check_field("floor", 8'(want.floor), 8'(got.floor));
                check_field("direction", 8'(want.direction), 8'(got.direction));
                check_field("doors_open", 8'(want.doors_open), 8'(got.doors_open));
                check_field("arrived", 8'(want.arrived), 8'(got.arrived));
                check_field("door_event", 8'(want.door_event), 8'(got.door_event));
                check_field("rejected", 8'(want.rejected), 8'(got.rejected));
                check_field("time_left", want.time_left, got.time_left);
            end
        end
    end

    task automatic reset_car_model();
        num_levels_r  = RST_NUM_LEVELS;
        move_delay_r  = RST_MOVE_DELAY;
        start_delay_r = RST_START_DELAY;
        stop_delay_r  = RST_STOP_DELAY;
        car_floor     = 4'd1;
        car_dir       = DIR_UP;
        saved_dir     = DIR_UP;
        doors_open    = 1'b0;
        calls         = '0;
        countdown     = 8'd1;
    endtask

    function automatic logic [4:0] served_levels();
        if (num_levels_r < 5'd2) return 5'd2;
        if (num_levels_r > TOP_LEVELS) return TOP_LEVELS;
        return num_levels_r;
    endfunction

    function automatic logic [7:0] pick_delay(input logic [7:0] d);
        return (d == 8'd0) ? ZERO_DELAY_SUB : d;
    endfunction

    // advance the car for one request and return the status it reports
    task automatic predict_car(input req_t kind, input logic [4:0] lvl, output result_t res);
        logic [4:0] n;
        logic       arrived;
        logic       rejected;
        door_evt_t  evt;
        n        = served_levels();
        arrived  = 1'b0;
        rejected = 1'b0;
        evt      = DOOR_NONE;
        case (kind) inside
            REQ_TICK: begin
                if (countdown > 8'd1) begin
                    countdown = countdown - 8'd1;
                end else if (car_dir != DIR_STOP) begin
                    // move one floor, saturating at the shaft ends
                    if (car_dir == DIR_UP) begin
                        if (car_floor < LAST_FLOOR) car_floor = car_floor + 4'd1;
                    end else if (car_floor > 4'd0) begin
                        car_floor = car_floor - 4'd1;
                    end
                    arrived = 1'b1;
                    if (car_floor == 4'd0) car_dir = DIR_UP;
                    if ({1'b0, car_floor} >= n - 5'd1) car_dir = DIR_DOWN;
                    // stop here if a call is latched
                    if (calls[car_floor]) begin
                        calls[car_floor] = 1'b0;
                        doors_open = 1'b1;
                        evt        = DOOR_OPENED;
                        saved_dir  = car_dir;
                        car_dir    = DIR_STOP;
                        countdown  = pick_delay(stop_delay_r);
                    end else begin
                        countdown = pick_delay(move_delay_r);
                    end
                end else begin
                    // stopped car closes and resumes
                    doors_open = 1'b0;
                    evt        = DOOR_CLOSED;
                    car_dir    = saved_dir;
                    countdown  = pick_delay(start_delay_r);
                end
            end
            REQ_LANDING, REQ_INSIDE: begin
                if (lvl == 5'd0 || lvl > n) begin
                    rejected = 1'b1;
                end else begin
                    calls[4'(lvl - 5'd1)] = 1'b1;
                    if (kind == REQ_INSIDE && doors_open) countdown = 8'd1;
                end
            end
            default: begin
                if (doors_open) countdown = 8'd1;
                else rejected = 1'b1;
            end
        endcase
        res.floor      = car_floor;
        res.direction  = car_dir;
        res.doors_open = doors_open;
        res.arrived    = arrived;
        res.door_event = evt;
        res.rejected   = rejected;
        res.time_left  = countdown;
    endtask

    // drive one request beat and record its predicted status on acceptance
    task automatic send_req(input req_t kind, input logic [4:0] lvl);
        result_t want;
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, lvl};
        do @(posedge aclk); while (!s_tready);
        predict_car(kind, lvl, want);
        car_status_q.push_back(want);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (car_status_q.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_NUM_LEVELS:  num_levels_r  = val[4:0];
            CFG_MOVE_DELAY:  move_delay_r  = val;
            CFG_START_DELAY: start_delay_r = val;
            default:         stop_delay_r  = val;
        endcase
    endtask

    function automatic logic [4:0] rand_level();
        return 5'($urandom_range(31));
    endfunction

    // mostly a served floor, sometimes anything the field can hold
    function automatic logic [4:0] pick_level();
        if ($urandom_range(99) < 75) return 5'($urandom_range(32'(served_levels()), 1));
        return rand_level();
    endfunction

    // tick until the controller takes its next step
    task automatic tick_to_step();
        while (countdown > 8'd1) send_req(REQ_TICK, rand_level());
        send_req(REQ_TICK, rand_level());
    endtask

    // rejections, calls, forced steps and a full stop at reset settings
    task automatic test_requests_after_reset();
        send_req(REQ_CLOSE, 5'd0);
        send_req(REQ_LANDING, 5'd0);
        send_req(REQ_INSIDE, 5'd31);
        send_req(REQ_LANDING, 5'd4);
        send_req(REQ_LANDING, 5'd3);
        send_req(REQ_LANDING, 5'd1);
        send_req(REQ_TICK, 5'd0);
        send_req(REQ_INSIDE, 5'd0);
        send_req(REQ_CLOSE, 5'd17);
        send_req(REQ_TICK, 5'd31);
        send_req(REQ_INSIDE, 5'd2);
        send_req(REQ_CLOSE, 5'd0);
        tick_to_step();
        send_req(REQ_INSIDE, 5'd3);
        send_req(REQ_TICK, 5'd0);
    endtask

    // zero delays fall back to the default, then the longest delays
    task automatic test_delay_extremes();
        drain_results();
        write_reg(CFG_MOVE_DELAY, 8'd0);
        write_reg(CFG_START_DELAY, 8'd0);
        write_reg(CFG_STOP_DELAY, 8'd0);
        send_req(REQ_LANDING, 5'd2);
        repeat (4) tick_to_step();
        drain_results();
        write_reg(CFG_MOVE_DELAY, 8'd255);
        write_reg(CFG_START_DELAY, 8'd255);
        write_reg(CFG_STOP_DELAY, 8'd255);
        tick_to_step();
        for (int lvl = 1; lvl <= 3; lvl++) send_req(REQ_LANDING, 5'(lvl));
        // close button cuts the long open time short
        send_req(REQ_CLOSE, 5'd0);
        tick_to_step();
        send_req(REQ_CLOSE, 5'd0);
        tick_to_step();
    endtask

    // car above a lowered floor count turns back, high calls stay latched
    task automatic test_floor_count_changes();
        int guard;
        drain_results();
        write_reg(CFG_NUM_LEVELS, 8'd16);
        write_reg(CFG_MOVE_DELAY, 8'd1);
        write_reg(CFG_START_DELAY, 8'd1);
        write_reg(CFG_STOP_DELAY, 8'd1);
        send_req(REQ_CLOSE, 5'd0);
        tick_to_step();
        send_req(REQ_LANDING, 5'd16);
        send_req(REQ_INSIDE, 5'd10);
        guard = 0;
        while (car_floor < 4'd8 && guard < 64) begin
            tick_to_step();
            guard++;
        end
        drain_results();
        write_reg(CFG_NUM_LEVELS, 8'd1);
        send_req(REQ_INSIDE, 5'd15);
        repeat (4) tick_to_step();
        drain_results();
        write_reg(CFG_NUM_LEVELS, 8'd0);
        send_req(REQ_LANDING, 5'd2);
        send_req(REQ_LANDING, 5'd3);
        repeat (3) tick_to_step();
        drain_results();
        write_reg(CFG_NUM_LEVELS, 8'd31);
        guard = 0;
        while (calls[15] && guard < 80) begin
            tick_to_step();
            guard++;
        end
        send_req(REQ_INSIDE, 5'd16);
        tick_to_step();
    endtask

    function automatic logic [7:0] rand_delay();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 8'($urandom_range(255, 200));
        if (r < 15) return 8'd0;
        return 8'($urandom_range(4, 1));
    endfunction

    function automatic logic [7:0] rand_num_levels();
        logic [7:0] picks[9] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd8, 8'd16, 8'd17, 8'd31};
        if ($urandom_range(99) < 70) return picks[$urandom_range(8)];
        return 8'($urandom_range(31));
    endfunction

    // random traffic over several register settings
    task automatic test_random_traffic();
        int sel;
        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            write_reg(CFG_NUM_LEVELS, rand_num_levels());
            write_reg(CFG_MOVE_DELAY, rand_delay());
            write_reg(CFG_START_DELAY, rand_delay());
            write_reg(CFG_STOP_DELAY, rand_delay());
            // one phase runs with both sides streaming without gaps
            no_idle = (phase == 3);
            for (int i = 0; i < 40; i++) begin
                sel = $urandom_range(99);
                if (sel < 55) send_req(REQ_TICK, rand_level());
                else if (sel < 75) send_req(REQ_LANDING, pick_level());
                else if (sel < 90) send_req(REQ_INSIDE, pick_level());
                else send_req(REQ_CLOSE, rand_level());
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = CFG_NUM_LEVELS;
        cfg_wdata  = 8'd0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'd0;
        s_tuser    = REQ_TICK;
        m_tready   = 1'b0;
        no_idle    = 1'b0;
        mismatches = 0;
        reset_car_model();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_requests_after_reset();
        test_delay_extremes();
        test_floor_count_changes();
        test_random_traffic();

        drain_results();
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
